// ===== rtl/csp_pkg.sv =====
package csp_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int SPEED_W  = 14;
  localparam int SERR_W   = 15;
  localparam int PWM_W    = 12;
  localparam int OUT_W    = 21;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Arithmetic: coefficients are Q8.24, products are 64 bits, sums 66 bits
  localparam int COEF_BITS = 24;
  localparam int OPND_W    = 32;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 66;

  // Fixed Q8.24 constants
  localparam int CUR_SCALE_Q24  = 105543;     // 0.0062908728 A per count
  localparam int CUR_OFFSET_Q24 = 207089845;  // 12.3435166538 A
  localparam int FILT_IN_Q24    = 511034;     // 0.03046
  localparam int FILT_FB_Q24    = 15755484;   // 0.9391

  // Limits
  localparam int SPEED_MAX  = 5000;
  localparam int IREF_LIMIT = 9;
  localparam int DUTY_MIN   = 800;
  localparam int DUTY_MAX   = 3200;

  // Register map, by word index
  typedef enum logic [2:0] {
    REG_LOOP_MODE     = 3'd0,
    REG_OPEN_DUTY     = 3'd1,
    REG_SPEED_TARGET  = 3'd2,
    REG_SPEED_GAIN_N  = 3'd3,
    REG_SPEED_GAIN_P  = 3'd4,
    REG_CUR_GAIN_N    = 3'd5,
    REG_CUR_GAIN_P    = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  localparam logic [11:0] OPEN_DUTY_RST = 12'd2000;
  localparam logic signed [13:0] SPEED_TARGET_RST = 14'sd100;
  localparam logic signed [31:0] SPEED_GAIN_N_RST = 32'sd15100;
  localparam logic signed [31:0] SPEED_GAIN_P_RST = -32'sd15099;
  localparam logic signed [31:0] CUR_GAIN_N_RST   = 32'sd1789570;
  localparam logic signed [31:0] CUR_GAIN_P_RST   = -32'sd1565896;

  // Configuration seen by the datapath and controller
  typedef struct packed {
    logic                      loop_mode;
    logic [11:0]               open_duty;
    logic signed [SPEED_W-1:0] speed_target;
    logic signed [31:0]        speed_gain_now;
    logic signed [31:0]        speed_gain_prev;
    logic signed [31:0]        current_gain_now;
    logic signed [31:0]        current_gain_prev;
  } cfg_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MS_MEAS       = 3'd0,
    MS_SERR_NOW   = 3'd1,
    MS_SERR_PREV  = 3'd2,
    MS_MEAS_FILT  = 3'd3,
    MS_LMEAS_FILT = 3'd4,
    MS_LSMOOTH_FB = 3'd5,
    MS_CERR_NOW   = 3'd6,
    MS_CERR_PREV  = 3'd7
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    BIAS_MEAS = 2'd0,
    BIAS_FRAC = 2'd1,
    BIAS_COEF = 2'd2
  } bias_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      latch_in;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    bias_sel_t bias_sel;
    logic      ld_meas;
    logic      ld_iref;
    logic      ld_cerr;
    logic      ld_smooth;
    logic      ld_duty;
    logic      load_out;
    logic      commit;
  } cmd_t;

endpackage

// ===== rtl/cascaded_speed_current_pi_core.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | current_sample, speed_rpm
// output   | out_valid / out_ready| pwm_compare, current_reference,
//          |                      | current_measured, current_smoothed
// config   | APB psel/penable     | paddr, pwdata, prdata
//
// Closed and open loop share one 32x32 multiplier that forms one of eight
// products per cycle; open loop stops after the measurement step.
// A new item is taken once the previous one has been placed in the output
// register; a stalled output holds the next item's last step until taken.
// rst (synchronous) restores register defaults and clears the loop state.
module cascaded_speed_current_pi_core
  import csp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_W-1:0]       current_sample,
  input  logic signed [SPEED_W-1:0] speed_rpm,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PWM_W-1:0]          pwm_compare,
  output logic signed [OUT_W-1:0]   current_reference,
  output logic signed [OUT_W-1:0]   current_measured,
  output logic signed [OUT_W-1:0]   current_smoothed,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  cfg_t cfg;
  cmd_t cmd;

  csp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .loop_mode (cfg.loop_mode),
    .cmd       (cmd)
  );

  csp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .current_sample    (current_sample),
    .speed_rpm         (speed_rpm),
    .pwm_compare       (pwm_compare),
    .current_reference (current_reference),
    .current_measured  (current_measured),
    .current_smoothed  (current_smoothed)
  );

endmodule

// ===== rtl/csp_regs.sv =====
module csp_regs
  import csp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode         <= 1'b0;
      cfg.open_duty         <= OPEN_DUTY_RST;
      cfg.speed_target      <= SPEED_TARGET_RST;
      cfg.speed_gain_now    <= SPEED_GAIN_N_RST;
      cfg.speed_gain_prev   <= SPEED_GAIN_P_RST;
      cfg.current_gain_now  <= CUR_GAIN_N_RST;
      cfg.current_gain_prev <= CUR_GAIN_P_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LOOP_MODE:    cfg.loop_mode         <= pwdata[0];
        REG_OPEN_DUTY:    cfg.open_duty         <= pwdata[11:0];
        REG_SPEED_TARGET: cfg.speed_target      <= pwdata[SPEED_W-1:0];
        REG_SPEED_GAIN_N: cfg.speed_gain_now    <= pwdata;
        REG_SPEED_GAIN_P: cfg.speed_gain_prev   <= pwdata;
        REG_CUR_GAIN_N:   cfg.current_gain_now  <= pwdata;
        REG_CUR_GAIN_P:   cfg.current_gain_prev <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_LOOP_MODE:    prdata = {{(DATA_W-1){1'b0}}, cfg.loop_mode};
      REG_OPEN_DUTY:    prdata = {{(DATA_W-12){1'b0}}, cfg.open_duty};
      REG_SPEED_TARGET: prdata = {{(DATA_W-SPEED_W){cfg.speed_target[SPEED_W-1]}},
                                  cfg.speed_target};
      REG_SPEED_GAIN_N: prdata = cfg.speed_gain_now;
      REG_SPEED_GAIN_P: prdata = cfg.speed_gain_prev;
      REG_CUR_GAIN_N:   prdata = cfg.current_gain_now;
      REG_CUR_GAIN_P:   prdata = cfg.current_gain_prev;
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/csp_ctrl.sv =====
module csp_ctrl
  import csp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic loop_mode,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_T1   = 12'b0000_0000_0010,
    ST_T2   = 12'b0000_0000_0100,
    ST_T3   = 12'b0000_0000_1000,
    ST_T4   = 12'b0000_0001_0000,
    ST_T5   = 12'b0000_0010_0000,
    ST_T6   = 12'b0000_0100_0000,
    ST_T7   = 12'b0000_1000_0000,
    ST_T8   = 12'b0001_0000_0000,
    ST_T9   = 12'b0010_0000_0000,
    ST_T10  = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Schedule: one product issued per cycle, summed the cycle after
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = MS_MEAS;
    cmd.acc_op   = ACC_HOLD;
    cmd.bias_sel = BIAS_MEAS;
    case (state)
      ST_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) state_next = ST_T1;
      end
      ST_T1: begin
        cmd.mul_sel = MS_MEAS;
        state_next  = ST_T2;
      end
      ST_T2: begin
        cmd.acc_op   = ACC_LOAD;
        cmd.bias_sel = BIAS_MEAS;
        cmd.mul_sel  = MS_SERR_NOW;
        state_next   = ST_T3;
      end
      ST_T3: begin
        cmd.ld_meas  = 1'b1;
        cmd.acc_op   = ACC_LOAD;
        cmd.bias_sel = BIAS_FRAC;
        cmd.mul_sel  = MS_SERR_PREV;
        state_next   = loop_mode ? ST_T4 : ST_FIN;
      end
      ST_T4: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MS_MEAS_FILT;
        state_next  = ST_T5;
      end
      ST_T5: begin
        cmd.ld_iref  = 1'b1;
        cmd.acc_op   = ACC_LOAD;
        cmd.bias_sel = BIAS_COEF;
        cmd.mul_sel  = MS_LMEAS_FILT;
        state_next   = ST_T6;
      end
      ST_T6: begin
        cmd.ld_cerr = 1'b1;
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MS_LSMOOTH_FB;
        state_next  = ST_T7;
      end
      ST_T7: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MS_CERR_NOW;
        state_next  = ST_T8;
      end
      ST_T8: begin
        cmd.ld_smooth = 1'b1;
        cmd.acc_op    = ACC_LOAD;
        cmd.bias_sel  = BIAS_COEF;
        cmd.mul_sel   = MS_CERR_PREV;
        state_next    = ST_T9;
      end
      ST_T9: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_T10;
      end
      ST_T10: begin
        cmd.ld_duty = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.commit   = loop_mode;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_T1))
    else $error("accepted item did not start the sequence");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten while waiting");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
  a_open_no_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit || cmd.ld_duty) |-> loop_mode)
    else $error("loop state touched in open loop");
`endif

endmodule

// ===== rtl/csp_dp.sv =====
module csp_dp
  import csp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  input  logic [SAMPLE_W-1:0]        current_sample,
  input  logic signed [SPEED_W-1:0]  speed_rpm,
  output logic [PWM_W-1:0]           pwm_compare,
  output logic signed [OUT_W-1:0]    current_reference,
  output logic signed [OUT_W-1:0]    current_measured,
  output logic signed [OUT_W-1:0]    current_smoothed
);

  // Value widths: measured and reference, errors and filter, duty
  localparam int VW = FRAC_BITS + 5;
  localparam int EW = FRAC_BITS + 6;
  localparam int DW = FRAC_BITS + 13;
  localparam int SH = COEF_BITS - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF_FRAC = (ACC_W'(1) << SH) >> 1;
  localparam logic signed [ACC_W-1:0] HALF_COEF = ACC_W'(1) << (COEF_BITS - 1);
  localparam logic signed [ACC_W-1:0] BIAS_M    = HALF_FRAC - ACC_W'(CUR_OFFSET_Q24);
  localparam logic signed [ACC_W-1:0] IREF_HI   = ACC_W'(IREF_LIMIT) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] IREF_LO   = -IREF_HI;
  localparam logic signed [ACC_W-1:0] DUTY_HI   = ACC_W'(DUTY_MAX) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] DUTY_LO   = ACC_W'(DUTY_MIN) << FRAC_BITS;

  // Item registers
  logic [SAMPLE_W-1:0]      sample;
  logic signed [SERR_W-1:0] speed_err;
  logic signed [VW-1:0]     measured;
  logic signed [VW-1:0]     iref;
  logic signed [EW-1:0]     cur_err;
  logic signed [EW-1:0]     smoothed;
  logic signed [DW-1:0]     duty;

  // Loop state
  logic signed [SERR_W-1:0] last_serr;
  logic signed [VW-1:0]     last_iref;
  logic signed [EW-1:0]     last_cerr;
  logic signed [DW-1:0]     last_duty;
  logic signed [EW-1:0]     last_smooth;
  logic signed [VW-1:0]     last_meas;

  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, bias, frac_sum, coef_sum;
  logic signed [ACC_W-1:0]  iref_sum, duty_sum;
  logic signed [SPEED_W-1:0] target_sat;
  logic signed [VW-1:0]     iref_next;
  logic signed [DW-1:0]     duty_next;

  // Saturated speed target
  assign target_sat = (cfg.speed_target > SPEED_W'(SPEED_MAX)) ?
                      SPEED_W'(SPEED_MAX) : cfg.speed_target;

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_MEAS: begin
        mul_a = OPND_W'({1'b0, sample});
        mul_b = OPND_W'(CUR_SCALE_Q24);
      end
      MS_SERR_NOW: begin
        mul_a = OPND_W'(speed_err);
        mul_b = cfg.speed_gain_now;
      end
      MS_SERR_PREV: begin
        mul_a = OPND_W'(last_serr);
        mul_b = cfg.speed_gain_prev;
      end
      MS_MEAS_FILT: begin
        mul_a = OPND_W'(measured);
        mul_b = OPND_W'(FILT_IN_Q24);
      end
      MS_LMEAS_FILT: begin
        mul_a = OPND_W'(last_meas);
        mul_b = OPND_W'(FILT_IN_Q24);
      end
      MS_LSMOOTH_FB: begin
        mul_a = OPND_W'(last_smooth);
        mul_b = OPND_W'(FILT_FB_Q24);
      end
      MS_CERR_NOW: begin
        mul_a = OPND_W'(cur_err);
        mul_b = cfg.current_gain_now;
      end
      MS_CERR_PREV: begin
        mul_a = OPND_W'(last_cerr);
        mul_b = cfg.current_gain_prev;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding bias for a fresh sum
  always_comb begin
    case (cmd.bias_sel)
      BIAS_MEAS: bias = BIAS_M;
      BIAS_FRAC: bias = HALF_FRAC;
      BIAS_COEF: bias = HALF_COEF;
      default:   bias = '0;
    endcase
  end

  // Scale back to the value format, add the previous output, clamp
  assign frac_sum = acc >>> SH;
  assign coef_sum = acc >>> COEF_BITS;
  assign iref_sum = frac_sum + ACC_W'(last_iref);
  assign duty_sum = coef_sum + ACC_W'(last_duty);

  always_comb begin
    if (iref_sum > IREF_HI) begin
      iref_next = VW'(IREF_HI);
    end else if (iref_sum < IREF_LO) begin
      iref_next = VW'(IREF_LO);
    end else begin
      iref_next = VW'(iref_sum);
    end
    if (duty_sum > DUTY_HI) begin
      duty_next = DW'(DUTY_HI);
    end else if (duty_sum < DUTY_LO) begin
      duty_next = DW'(DUTY_LO);
    end else begin
      duty_next = DW'(duty_sum);
    end
  end

  // Product, accumulator and item registers
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (cmd.acc_op)
      ACC_LOAD: acc <= bias + ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default:  acc <= acc;
    endcase
    if (cmd.latch_in) begin
      sample    <= current_sample;
      speed_err <= SERR_W'(target_sat) - SERR_W'(speed_rpm);
    end
    if (cmd.ld_meas)   measured <= VW'(frac_sum);
    if (cmd.ld_iref)   iref     <= iref_next;
    if (cmd.ld_cerr)   cur_err  <= EW'(iref) - EW'(measured);
    if (cmd.ld_smooth) smoothed <= EW'(coef_sum);
    if (cmd.ld_duty)   duty     <= duty_next;
  end

  // Loop state update, closed loop only
  always_ff @(posedge clk) begin
    if (rst) begin
      last_serr   <= '0;
      last_iref   <= '0;
      last_cerr   <= '0;
      last_duty   <= '0;
      last_smooth <= '0;
      last_meas   <= '0;
    end else if (cmd.commit) begin
      last_serr   <= speed_err;
      last_iref   <= iref;
      last_cerr   <= cur_err;
      last_duty   <= duty;
      last_smooth <= smoothed;
      last_meas   <= measured;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      current_measured <= OUT_W'(measured);
      if (cfg.loop_mode) begin
        pwm_compare       <= duty[FRAC_BITS +: PWM_W] - PWM_W'(1);
        current_reference <= OUT_W'(iref);
        current_smoothed  <= OUT_W'(smoothed);
      end else begin
        pwm_compare       <= cfg.open_duty - PWM_W'(1);
        current_reference <= OUT_W'(last_iref);
        current_smoothed  <= OUT_W'(last_smooth);
      end
    end
  end

endmodule

// ===== tb/tb_cascaded_speed_current_pi_core.sv =====
`timescale 1ns / 1ps

module tb_cascaded_speed_current_pi_core;
  import csp_pkg::*;

  localparam int FRAC        = 16;
  localparam int DOWN        = COEF_BITS - FRAC;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 122;
  localparam int ZERO_AMP    = 1962;  // raw count that scales to about 0 A
  localparam int MAX_REPORTS = 10;

  // One control tick as seen on the output channel
  typedef struct packed {
    logic [PWM_W-1:0]        pwm;
    logic signed [OUT_W-1:0] iref;
    logic signed [OUT_W-1:0] meas;
    logic signed [OUT_W-1:0] smooth;
  } tick_out_t;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_KNOWN,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    reg_idx_t                  idx;
    logic [DATA_W-1:0]         value;
    logic [SAMPLE_W-1:0]       sample;
    logic signed [SPEED_W-1:0] speed;
    tick_out_t                 want;
  } row_t;

  typedef enum logic [1:0] {
    GAPS_NONE,
    GAPS_SENDER,
    GAPS_RECEIVER,
    GAPS_BOTH
  } gap_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [SAMPLE_W-1:0]       current_sample = '0;
  logic signed [SPEED_W-1:0] speed_rpm = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PWM_W-1:0]          pwm_compare;
  logic signed [OUT_W-1:0]   current_reference;
  logic signed [OUT_W-1:0]   current_measured;
  logic signed [OUT_W-1:0]   current_smoothed;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // Controller shadow: register copy and loop history
  cfg_t   shadow_cfg;
  longint prev_serr;
  longint prev_iref;
  longint prev_cerr;
  longint prev_duty;
  longint prev_smooth;
  longint prev_meas;

  tick_out_t due_outputs[$];
  row_t      script[$];
  int        mismatches = 0;
  int        send_gap_pct = 0;
  int        stall_pct = 0;
  tick_out_t seen_out;
  tick_out_t due_out;

  cascaded_speed_current_pi_core #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .current_sample(current_sample),
    .speed_rpm(speed_rpm),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pwm_compare(pwm_compare),
    .current_reference(current_reference),
    .current_measured(current_measured),
    .current_smoothed(current_smoothed),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Round half up: add half an LSB, then floor
  function automatic longint round_q(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_q(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // One control tick of the cascaded loop; updates the loop history in closed loop
  function automatic tick_out_t control_tick(logic [SAMPLE_W-1:0] sample,
                                             logic signed [SPEED_W-1:0] speed);
    longint    meas;
    longint    tgt;
    longint    serr;
    longint    iref;
    longint    smooth;
    longint    cerr;
    longint    duty;
    longint    ilim;
    tick_out_t r;
    meas = round_q(longint'(sample) * CUR_SCALE_Q24 - CUR_OFFSET_Q24, DOWN);
    if (!shadow_cfg.loop_mode) begin
      // open loop: fixed duty, history reported but untouched
      r.pwm    = PWM_W'(longint'(shadow_cfg.open_duty) - 1);
      r.iref   = prev_iref[OUT_W-1:0];
      r.meas   = meas[OUT_W-1:0];
      r.smooth = prev_smooth[OUT_W-1:0];
      return r;
    end
    tgt  = longint'(shadow_cfg.speed_target);
    if (tgt > SPEED_MAX) tgt = SPEED_MAX;
    serr = tgt - longint'(speed);
    ilim = longint'(IREF_LIMIT) <<< FRAC;
    // outer speed loop
    iref = round_q(serr * longint'(shadow_cfg.speed_gain_now) +
                   prev_serr * longint'(shadow_cfg.speed_gain_prev), DOWN) + prev_iref;
    iref = clamp_q(iref, -ilim, ilim);
    // current filter
    smooth = round_q(meas * FILT_IN_Q24 + prev_meas * FILT_IN_Q24 +
                     prev_smooth * FILT_FB_Q24, COEF_BITS);
    // inner current loop
    cerr = iref - meas;
    duty = round_q(cerr * longint'(shadow_cfg.current_gain_now) +
                   prev_cerr * longint'(shadow_cfg.current_gain_prev), COEF_BITS) + prev_duty;
    duty = clamp_q(duty, longint'(DUTY_MIN) <<< FRAC, longint'(DUTY_MAX) <<< FRAC);
    prev_smooth = smooth;
    prev_meas   = meas;
    prev_serr   = serr;
    prev_cerr   = cerr;
    prev_iref   = iref;
    prev_duty   = duty;
    r.pwm    = PWM_W'((duty >>> FRAC) - 1);
    r.iref   = iref[OUT_W-1:0];
    r.meas   = meas[OUT_W-1:0];
    r.smooth = smooth[OUT_W-1:0];
    return r;
  endfunction

  function automatic void add_tick(int sample, int speed);
    row_t row;
    row        = '0;
    row.kind   = ROW_TICK;
    row.sample = SAMPLE_W'(sample);
    row.speed  = SPEED_W'(speed);
    script.push_back(row);
  endfunction

  function automatic void add_known(int sample, int speed, int pwm, int iref, int meas,
                                    int smooth);
    row_t row;
    row             = '0;
    row.kind        = ROW_KNOWN;
    row.sample      = SAMPLE_W'(sample);
    row.speed       = SPEED_W'(speed);
    row.want.pwm    = PWM_W'(pwm);
    row.want.iref   = OUT_W'(iref);
    row.want.meas   = OUT_W'(meas);
    row.want.smooth = OUT_W'(smooth);
    script.push_back(row);
  endfunction

  function automatic void add_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    script.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain(logic signed [31:0] nominal);
    case ($urandom_range(3))
      0: return nominal;
      1: return DATA_W'(int'(nominal) + int'($urandom_range(8191)) - 4096);
      2: return $urandom();
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // APB write: setup then access, then an idle wait, shadow follows
  task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOOP_MODE:    shadow_cfg.loop_mode         = value[0];
      REG_OPEN_DUTY:    shadow_cfg.open_duty         = value[11:0];
      REG_SPEED_TARGET: shadow_cfg.speed_target      = value[SPEED_W-1:0];
      REG_SPEED_GAIN_N: shadow_cfg.speed_gain_now    = value;
      REG_SPEED_GAIN_P: shadow_cfg.speed_gain_prev   = value;
      REG_CUR_GAIN_N:   shadow_cfg.current_gain_now  = value;
      REG_CUR_GAIN_P:   shadow_cfg.current_gain_prev = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Present one item, wait for its handshake, queue its expected output
  task automatic send_tick(logic [SAMPLE_W-1:0] sample, logic signed [SPEED_W-1:0] speed,
                           bit known, tick_out_t want);
    tick_out_t model_out;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid       <= 1'b1;
    current_sample <= sample;
    speed_rpm      <= speed;
    do @(posedge clk); while (!in_ready);
    model_out = control_tick(sample, speed);
    due_outputs.push_back(known ? want : model_out);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic shuffle_settings(int p);
    int tgt;
    if (p % 3 == 0) tgt = int'($urandom_range(16383)) - 8192;
    else tgt = int'($urandom_range(5600)) - 300;
    write_register(REG_OPEN_DUTY, DATA_W'($urandom_range(4095)));
    write_register(REG_SPEED_TARGET, DATA_W'(tgt));
    write_register(REG_SPEED_GAIN_N, pick_gain(SPEED_GAIN_N_RST));
    write_register(REG_SPEED_GAIN_P, pick_gain(SPEED_GAIN_P_RST));
    write_register(REG_CUR_GAIN_N, pick_gain(CUR_GAIN_N_RST));
    write_register(REG_CUR_GAIN_P, pick_gain(CUR_GAIN_P_RST));
    write_register(REG_LOOP_MODE, (p == 5) ? 32'd0 : 32'd1);
  endtask

  task automatic report_bad(string what, tick_out_t want, tick_out_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected pwm=%0d iref=%0d meas=%0d smooth=%0d / got pwm=%0d",
               $realtime, what, want.pwm, want.iref, want.meas, want.smooth, seen.pwm,
               " iref=%0d meas=%0d smooth=%0d", seen.iref, seen.meas, seen.smooth);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Output checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_out = {pwm_compare, current_reference, current_measured, current_smoothed};
      if (due_outputs.size() == 0) begin
        report_bad("item with none expected", '0, seen_out);
      end else begin
        due_out = due_outputs.pop_front();
        if (seen_out.pwm !== due_out.pwm || seen_out.iref !== due_out.iref ||
            seen_out.meas !== due_out.meas || seen_out.smooth !== due_out.smooth)
          report_bad("mismatch", due_out, seen_out);
      end
    end
  end

  initial begin
    row_t row;
    int   spd;
    int   smp;
    int   tgt_now;

    shadow_cfg.loop_mode         = 1'b0;
    shadow_cfg.open_duty         = OPEN_DUTY_RST;
    shadow_cfg.speed_target      = SPEED_TARGET_RST;
    shadow_cfg.speed_gain_now    = SPEED_GAIN_N_RST;
    shadow_cfg.speed_gain_prev   = SPEED_GAIN_P_RST;
    shadow_cfg.current_gain_now  = CUR_GAIN_N_RST;
    shadow_cfg.current_gain_prev = CUR_GAIN_P_RST;
    prev_serr   = 0;
    prev_iref   = 0;
    prev_cerr   = 0;
    prev_duty   = 0;
    prev_smooth = 0;
    prev_meas   = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // open loop after reset: set duty minus one, zero history
    add_known(0, -8192, 1999, 0, -808945, 0);
    add_known(4095, 8191, 1999, 0, 879331, 0);
    add_write(REG_OPEN_DUTY, 32'd0);
    add_known(2048, 0, 4095, 0, 35399, 0);      // zero duty wraps
    add_write(REG_OPEN_DUTY, 32'd4095);
    add_known(1, 1, 4094, 0, -808532, 0);
    add_write(REG_OPEN_DUTY, 32'd1);
    add_known(4095, -1, 0, 0, 879331, 0);
    // closed loop with reset gains, speed and sample extremes
    add_write(REG_LOOP_MODE, 32'd1);
    add_tick(2048, -8192);
    add_tick(2048, 8191);
    add_tick(0, 0);
    add_tick(4095, 0);
    add_tick(ZERO_AMP, 100);
    // target above 5000 saturates
    add_write(REG_SPEED_TARGET, 32'd8191);
    add_tick(ZERO_AMP, 4000);
    add_tick(ZERO_AMP, 6000);
    add_write(REG_SPEED_TARGET, 32'hFFFF_E000);
    add_tick(ZERO_AMP, 8191);
    add_tick(ZERO_AMP, -8192);
    // extreme speed gains drive the reference into both 9 A clamps
    add_write(REG_SPEED_TARGET, 32'd5000);
    add_write(REG_SPEED_GAIN_N, 32'h7FFF_FFFF);
    add_write(REG_SPEED_GAIN_P, 32'h8000_0000);
    add_tick(0, -8192);
    add_tick(4095, 8191);
    // extreme current gains drive the duty into both clamps
    add_write(REG_CUR_GAIN_N, 32'h8000_0000);
    add_write(REG_CUR_GAIN_P, 32'h7FFF_FFFF);
    add_tick(4095, -8192);
    add_tick(0, 8191);
    add_tick(2000, 5000);
    // back to open loop: held reference and filter are reported
    add_write(REG_LOOP_MODE, 32'd0);
    add_tick(100, 0);

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_WRITE) begin
        drain_outputs();
        write_register(row.idx, row.value);
      end else begin
        send_tick(row.sample, row.speed, row.kind == ROW_KNOWN, row.want);
      end
    end

    // random phases, each with its own settings and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      drain_outputs();
      case (gap_mode_t'(p % 4))
        GAPS_NONE: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        GAPS_SENDER: begin
          send_gap_pct = 83;
          stall_pct    = 0;
        end
        GAPS_RECEIVER: begin
          send_gap_pct = 0;
          stall_pct    = 83;
        end
        default: begin
          send_gap_pct = 17;
          stall_pct    = 17;
        end
      endcase
      shuffle_settings(p);
      tgt_now = int'(shadow_cfg.speed_target);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 70) begin
          // tracking: speed near the target, current near zero
          spd = tgt_now + int'($urandom_range(600)) - 300;
          smp = ZERO_AMP + int'($urandom_range(800)) - 400;
          if (spd > 8191) spd = 8191;
          if (spd < -8192) spd = -8192;
        end else begin
          spd = int'($urandom_range(16383)) - 8192;
          smp = int'($urandom_range(4095));
        end
        send_tick(SAMPLE_W'(smp), SPEED_W'(spd), 1'b0, '0);
      end
    end

    drain_outputs();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
